@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/gcpm_pkg.sv @@
// ---------------------------------------------------------------------------
// gcpm_pkg
// Types, codes and constants shared by the consensus phase machine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcpm_pkg;

    localparam int VECTOR_LENGTH_DEFAULT = 8;

    localparam logic [31:0] RESET_SEED         = 32'h9E37_79B9;
    localparam logic [15:0] EPSILON_RESET      = 16'd4;
    localparam logic [16:0] CONV_THRESH_RESET  = 17'd62259;
    localparam logic [16:0] DIV_THRESH_RESET   = 17'd64881;
    localparam logic [7:0]  RUN_LENGTH_RESET   = 8'd16;
    localparam logic [30:0] CLAMP_LIMIT_RESET  = 31'd1048576;
    localparam logic [7:0]  COUNT_MAX          = 8'hFF;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_ORDER = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_EPSILON     = 3'd0,
        CFG_CONV_THRESH = 3'd1,
        CFG_DIV_THRESH  = 3'd2,
        CFG_RUN_LENGTH  = 3'd3,
        CFG_CLAMP_LIMIT = 3'd4,
        CFG_SEED        = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_KICK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SMOOTH,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] data;
    } cell_cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         index;
        logic signed [31:0] component_value;
        logic [16:0]        order_value;
    } in_item_t;

    typedef struct packed {
        logic               phase;
        logic               transitioned;
        logic               converged;
        logic [31:0]        max_change;
        logic signed [31:0] component;
        logic               order_seen;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/gcpm_cell.sv @@
// ---------------------------------------------------------------------------
// gcpm_cell
// One vector component: smoothing datapath, load, and shift-chain links.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcpm_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gcpm_pkg::cell_cmd_t cmd,
    input  wire logic signed [31:0]  left_value,
    input  wire logic signed [31:0]  right_value,
    input  wire logic signed [31:0]  shift_value,
    input  wire logic [31:0]         shift_delta,
    output logic signed [31:0]       value,
    output logic [31:0]              delta
);

    logic signed [31:0] value_reg;
    logic [31:0]        delta_reg;
    logic signed [33:0] sum;
    logic signed [33:0] fresh_wide;
    logic signed [31:0] fresh;
    logic signed [32:0] diff;
    logic signed [32:0] diff_abs;

    // (left + 2*centre + right) / 4, truncated toward zero
    always_comb
    begin
        sum = 34'(left_value) + (34'(value_reg) <<< 1) + 34'(right_value);
        if (sum < 0)
            fresh_wide = (sum + 34'sd3) >>> 2;
        else
            fresh_wide = sum >>> 2;
        fresh    = fresh_wide[31:0];
        diff     = 33'(fresh) - 33'(value_reg);
        diff_abs = (diff < 0) ? -diff : diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
        begin
            case (cmd.op)
                gcpm_pkg::CELL_LOAD:   value_reg <= cmd.data;
                gcpm_pkg::CELL_SMOOTH: value_reg <= fresh;
                gcpm_pkg::CELL_ROTATE: value_reg <= shift_value;
                default:               value_reg <= value_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            gcpm_pkg::CELL_SMOOTH: delta_reg <= diff_abs[31:0];
            gcpm_pkg::CELL_SHIFT:  delta_reg <= shift_delta;
            default:               delta_reg <= delta_reg;
        endcase
    end

    assign value = value_reg;
    assign delta = delta_reg;

endmodule

`default_nettype wire

@@ rtl/gcpm_kick.sv @@
// ---------------------------------------------------------------------------
// gcpm_kick
// Xorshift32 generator and the clamped kick applied at the head of the ring.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcpm_kick (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               seed_load,
    input  wire logic [31:0]        seed,
    input  wire logic [30:0]        clamp_limit,
    input  wire logic signed [31:0] value_in,
    output logic signed [31:0]      value_out
);

    logic [31:0]        gen_reg;
    logic [31:0]        gen_next;
    logic [31:0]        x1;
    logic [31:0]        x2;
    logic [31:0]        x3;
    logic [7:0]         kick_byte;
    logic signed [32:0] kick;
    logic signed [33:0] total;
    logic signed [33:0] lim_pos;
    logic signed [33:0] lim_neg;
    logic signed [33:0] clamped;

    always_comb
    begin
        x1        = gen_reg ^ (gen_reg << 13);
        x2        = x1 ^ (x1 >> 17);
        x3        = x2 ^ (x2 << 5);
        // a zero draw is replaced by one
        gen_next  = (x3 == '0) ? 32'd1 : x3;
        kick_byte = gen_next[7:0];
        kick      = {{16{kick_byte[7]}}, kick_byte, 9'b0};
        total     = 34'(value_in) + 34'(kick);
        lim_pos   = {3'b000, clamp_limit};
        lim_neg   = -lim_pos;
        if (total > lim_pos)
            clamped = lim_pos;
        else if (total < lim_neg)
            clamped = lim_neg;
        else
            clamped = total;
    end

    assign value_out = clamped[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gen_reg <= gcpm_pkg::RESET_SEED;
        else if (seed_load)
            gen_reg <= (seed == '0) ? 32'd1 : seed;
        else if (advance)
            gen_reg <= gen_next;
    end

endmodule

`default_nettype wire

@@ rtl/gated_consensus_phase_machine_core.sv @@
// ---------------------------------------------------------------------------
// gated_consensus_phase_machine_core
// Circular Q16.16 vector in a ring of cells with a gated two-phase mode.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------
//  in       | input     | in_valid / in_stall | in_data   (gcpm_pkg::in_item_t)
//  out      | output    | out_valid/out_stall | out_data  (gcpm_pkg::out_item_t)
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Load, order update and read go from idle straight to the finish state;
//  a smoothing step updates all cells together, then the change values
//  shift one cell a cycle into the max tracker; a divergent step rotates
//  the ring once past the single kick unit before the finish state.
//  One item is in work at a time; the output register lets the next item
//  start while a result is stalled. Asynchronous reset, no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gated_consensus_phase_machine_core #(
    parameter int VECTOR_LENGTH = gcpm_pkg::VECTOR_LENGTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire gcpm_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output gcpm_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int CNT_W = $clog2(VECTOR_LENGTH);

    gcpm_pkg::state_t    state_reg;
    gcpm_pkg::state_t    state_next;

    logic [15:0]         epsilon_reg;
    logic [16:0]         conv_thresh_reg;
    logic [16:0]         div_thresh_reg;
    logic [7:0]          run_length_reg;
    logic [30:0]         clamp_limit_reg;

    logic                phase_reg;
    logic                consensus_reg;
    logic [7:0]          dcount_reg;
    logic [16:0]         last_order_reg;
    logic                order_rcvd_reg;
    logic [31:0]         max_reg;
    logic [CNT_W-1:0]    cnt_reg;
    gcpm_pkg::kind_t     kind_reg;
    logic [2:0]          idx_reg;

    logic                out_valid_reg;
    gcpm_pkg::out_item_t out_data_reg;

    logic                accept;
    logic                cfg_write;
    logic                out_free;
    logic                finish_fire;
    logic                kick_advance;
    logic                seed_load;
    logic                cons_new;
    logic                trans_conv;
    logic [7:0]          dcount_inc;
    logic                trans_div;
    logic signed [31:0]  comp_sel;
    logic signed [31:0]  kicked_value;

    gcpm_pkg::cell_cmd_t cell_cmd   [VECTOR_LENGTH];
    logic signed [31:0]  cell_value [VECTOR_LENGTH];
    logic [31:0]         cell_delta [VECTOR_LENGTH];

    assign in_stall    = (state_reg != gcpm_pkg::ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign out_free    = !out_valid_reg || !out_stall;
    assign finish_fire = (state_reg == gcpm_pkg::ST_FINISH) && out_free;
    assign seed_load   = cfg_write && (cfg_index == gcpm_pkg::CFG_SEED);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg     <= gcpm_pkg::EPSILON_RESET;
            conv_thresh_reg <= gcpm_pkg::CONV_THRESH_RESET;
            div_thresh_reg  <= gcpm_pkg::DIV_THRESH_RESET;
            run_length_reg  <= gcpm_pkg::RUN_LENGTH_RESET;
            clamp_limit_reg <= gcpm_pkg::CLAMP_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gcpm_pkg::CFG_EPSILON:     epsilon_reg     <= cfg_data[15:0];
                gcpm_pkg::CFG_CONV_THRESH: conv_thresh_reg <= cfg_data[16:0];
                gcpm_pkg::CFG_DIV_THRESH:  div_thresh_reg  <= cfg_data[16:0];
                gcpm_pkg::CFG_RUN_LENGTH:  run_length_reg  <= cfg_data[7:0];
                gcpm_pkg::CFG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[30:0];
                default:                   ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.kind == gcpm_pkg::KIND_STEP)
                        state_next = phase_reg ? gcpm_pkg::ST_KICK : gcpm_pkg::ST_SCAN;
                    else
                        state_next = gcpm_pkg::ST_FINISH;
                end
            end
            gcpm_pkg::ST_SCAN,
            gcpm_pkg::ST_KICK:
            begin
                if (cnt_reg == '0)
                    state_next = gcpm_pkg::ST_FINISH;
            end
            gcpm_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = gcpm_pkg::ST_IDLE;
            end
            default: state_next = gcpm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gcpm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // cell commands and kick advance
    always_comb
    begin
        kick_advance = 1'b0;
        for (int i = 0; i < VECTOR_LENGTH; i++)
        begin
            cell_cmd[i].op   = gcpm_pkg::CELL_HOLD;
            cell_cmd[i].data = in_data.component_value;
        end
        unique case (state_reg)
            gcpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.kind)
                        gcpm_pkg::KIND_LOAD:
                        begin
                            for (int i = 0; i < VECTOR_LENGTH; i++)
                            begin
                                if (int'(in_data.index) == i)
                                    cell_cmd[i].op = gcpm_pkg::CELL_LOAD;
                            end
                        end
                        gcpm_pkg::KIND_STEP:
                        begin
                            kick_advance = phase_reg;
                            for (int i = 0; i < VECTOR_LENGTH; i++)
                                cell_cmd[i].op = phase_reg ? gcpm_pkg::CELL_ROTATE
                                                           : gcpm_pkg::CELL_SMOOTH;
                        end
                        default: ;
                    endcase
                end
            end
            gcpm_pkg::ST_SCAN:
            begin
                for (int i = 0; i < VECTOR_LENGTH; i++)
                    cell_cmd[i].op = gcpm_pkg::CELL_SHIFT;
            end
            gcpm_pkg::ST_KICK:
            begin
                kick_advance = 1'b1;
                for (int i = 0; i < VECTOR_LENGTH; i++)
                    cell_cmd[i].op = gcpm_pkg::CELL_ROTATE;
            end
            default: ;
        endcase
    end

    // ring of cells; values and changes move toward cell 0
    for (genvar g = 0; g < VECTOR_LENGTH; g++)
    begin : g_cell
        logic signed [31:0] shift_value;
        logic [31:0]        shift_delta;

        if (g == VECTOR_LENGTH - 1)
        begin : g_tail
            assign shift_value = kicked_value;
            assign shift_delta = '0;
        end
        else
        begin : g_link
            assign shift_value = cell_value[g + 1];
            assign shift_delta = cell_delta[g + 1];
        end

        gcpm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd[g]),
            .left_value  (cell_value[(g + VECTOR_LENGTH - 1) % VECTOR_LENGTH]),
            .right_value (cell_value[(g + 1) % VECTOR_LENGTH]),
            .shift_value (shift_value),
            .shift_delta (shift_delta),
            .value       (cell_value[g]),
            .delta       (cell_delta[g])
        );
    end

    gcpm_kick u_kick (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (kick_advance),
        .seed_load   (seed_load),
        .seed        (cfg_data),
        .clamp_limit (clamp_limit_reg),
        .value_in    (cell_value[0]),
        .value_out   (kicked_value)
    );

    // per-item bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= gcpm_pkg::KIND_LOAD;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            max_reg        <= '0;
            last_order_reg <= '0;
            order_rcvd_reg <= 1'b0;
        end
        else if (accept)
        begin
            kind_reg <= in_data.kind;
            idx_reg  <= in_data.index;
            max_reg  <= '0;
            cnt_reg  <= phase_reg ? CNT_W'(VECTOR_LENGTH - 2) : CNT_W'(VECTOR_LENGTH - 1);
            if (in_data.kind == gcpm_pkg::KIND_ORDER)
            begin
                last_order_reg <= in_data.order_value;
                order_rcvd_reg <= 1'b1;
            end
        end
        else if (state_reg == gcpm_pkg::ST_SCAN)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cell_delta[0] > max_reg)
                max_reg <= cell_delta[0];
        end
        else if (state_reg == gcpm_pkg::ST_KICK)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // phase decisions
    always_comb
    begin
        cons_new   = consensus_reg || (max_reg < {16'b0, epsilon_reg});
        trans_conv = order_rcvd_reg && cons_new && (last_order_reg < div_thresh_reg);
        dcount_inc = (dcount_reg == gcpm_pkg::COUNT_MAX) ? dcount_reg : dcount_reg + 8'd1;
        trans_div  = order_rcvd_reg && (dcount_inc >= run_length_reg)
                     && (last_order_reg >= conv_thresh_reg);
        comp_sel   = '0;
        for (int i = 0; i < VECTOR_LENGTH; i++)
        begin
            if (int'(idx_reg) == i)
                comp_sel = cell_value[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            consensus_reg <= 1'b0;
            dcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish_fire)
            begin
                out_valid_reg <= 1'b1;
                if (kind_reg == gcpm_pkg::KIND_STEP)
                begin
                    if (!phase_reg)
                    begin
                        consensus_reg <= cons_new;
                        if (trans_conv)
                        begin
                            phase_reg  <= 1'b1;
                            dcount_reg <= '0;
                        end
                    end
                    else
                    begin
                        dcount_reg <= dcount_inc;
                        if (trans_div)
                        begin
                            phase_reg     <= 1'b0;
                            consensus_reg <= 1'b0;
                        end
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            if (kind_reg == gcpm_pkg::KIND_STEP)
            begin
                if (!phase_reg)
                begin
                    out_data_reg.phase        <= trans_conv;
                    out_data_reg.transitioned <= trans_conv;
                    out_data_reg.converged    <= cons_new;
                end
                else
                begin
                    out_data_reg.phase        <= !trans_div;
                    out_data_reg.transitioned <= trans_div;
                    out_data_reg.converged    <= trans_div ? 1'b0 : consensus_reg;
                end
            end
            else
            begin
                out_data_reg.phase        <= phase_reg;
                out_data_reg.transitioned <= 1'b0;
                out_data_reg.converged    <= consensus_reg;
            end
            out_data_reg.max_change <= max_reg;
            out_data_reg.component  <= comp_sel;
            out_data_reg.order_seen <= order_rcvd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_NEXT(a_div_step_kicks, clk, rst_n,
                 accept && (in_data.kind == gcpm_pkg::KIND_STEP) && phase_reg,
                 state_reg == gcpm_pkg::ST_KICK)
    `ASSERT_NEXT(a_scan_ends, clk, rst_n,
                 (state_reg == gcpm_pkg::ST_SCAN) && (cnt_reg == '0),
                 state_reg == gcpm_pkg::ST_FINISH)
    `ASSERT_IMPLIES(a_result_from_finish, clk, rst_n,
                    $rose(out_valid_reg), $past(state_reg == gcpm_pkg::ST_FINISH))
    `ASSERT_IMPLIES(a_kick_max_zero, clk, rst_n,
                    state_reg == gcpm_pkg::ST_KICK, max_reg == '0)

endmodule

`default_nettype wire
